// ===== src/csls_pkg.sv =====
// Package for the cloud sample shading block: word types, register indexes,
// widths, pipeline latencies and the exp(-x) table. Depends on nothing.
`timescale 1ns / 1ps
package csls_pkg;

  localparam int EXP_TABLE_DEPTH = 256;
  localparam int EXP_IDX_W = $clog2(EXP_TABLE_DEPTH);
  localparam int EXP_ROM_W = $clog2(EXP_TABLE_DEPTH + 1);
  localparam int EXP_ARG_W = 30;
  localparam int EXP_VAL_W = 17;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic signed [14:0] G_LIMIT = 15'sd15565;
  localparam logic [28:0] INV_FOUR_PI = 29'd341782638;

  localparam int SQRT_STEPS = 29;
  localparam int DIV_STEPS = 30;
  localparam int LOBE_W = 23;
  localparam int PHASE_W = 26;
  localparam int LOBE_LAT = SQRT_STEPS + DIV_STEPS + 6;
  localparam int STG_PHASE = 2 + LOBE_LAT + 2;
  localparam int STG_LAST = STG_PHASE + 4;
  localparam int SIDE_LEN = STG_PHASE - 5 + 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SUN_COLOR,
    CFG_SUN_STRENGTH,
    CFG_SKY_TOP,
    CFG_SKY_BOTTOM,
    CFG_LOBE_FWD_G,
    CFG_LOBE_BACK_G,
    CFG_LOBE_BACK_W,
    CFG_ATTEN
  } cfg_idx_e;

  typedef struct packed {
    logic [15:0]        sample_density;
    logic [15:0]        depth_to_sun;
    logic [16:0]        height_frac;
    logic signed [15:0] view_x;
    logic signed [15:0] view_y;
    logic signed [15:0] view_z;
    logic signed [15:0] light_x;
    logic signed [15:0] light_y;
    logic signed [15:0] light_z;
  } sample_t;

  typedef struct packed {
    logic [15:0] red_out;
    logic [15:0] green_out;
    logic [15:0] blue_out;
  } shade_t;

  typedef logic [EXP_VAL_W-1:0] exp_rom_t [EXP_TABLE_DEPTH+1];

  // Samples of exp(-x) over [0,16] in Q1.16, built from a Taylor series of one step.
  function automatic exp_rom_t build_exp_rom();
    exp_rom_t    rom;
    logic [63:0] one;
    logic [63:0] step;
    logic [63:0] sum;
    logic [63:0] term;
    logic [63:0] cur;
    one  = 64'd1 << 30;
    step = (64'd1 << 34) / EXP_TABLE_DEPTH;
    sum  = one;
    term = one;
    cur  = one;
    for (int n = 1; n <= 12; n++) begin
      term = ((term * step + (one >> 1)) >> 30) / 64'(n);
      if (n[0]) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    for (int i = 0; i <= EXP_TABLE_DEPTH; i++) begin
      rom[i] = EXP_VAL_W'((cur + (64'd1 << 13)) >> 14);
      cur = (cur * sum + (one >> 1)) >> 30;
    end
    return rom;
  endfunction

  localparam exp_rom_t EXP_ROM = build_exp_rom();

endpackage

// ===== src/csls_stream_if.sv =====
// Valid/ready channels that carry one sample word in and one shade word out.
// Depends on csls_pkg for the word types.
`timescale 1ns / 1ps
interface csls_sample_if import csls_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface csls_shade_if import csls_pkg::*; ();
  logic   valid;
  logic   ready;
  shade_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== src/csls_exp_neg.sv =====
// Two-stage exp(-x) unit: table lookup, then linear interpolation.
// Depends on csls_pkg for the table and widths.
`timescale 1ns / 1ps
module csls_exp_neg import csls_pkg::*; (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic [EXP_ARG_W-1:0] arg_i,
  output logic [EXP_VAL_W-1:0] val_o
);

  localparam int PosW = 20 + EXP_IDX_W + 1;

  logic                 zero;
  logic [PosW-1:0]      prod;
  logic [PosW-5:0]      pos;
  logic [EXP_IDX_W-1:0] idx;
  logic [EXP_VAL_W-1:0] a;
  logic [EXP_VAL_W-1:0] b;
  logic [EXP_VAL_W-1:0] a_q;
  logic [EXP_VAL_W-1:0] diff_q;
  logic [15:0]          frac_q;
  logic                 zero_q;
  logic [EXP_VAL_W+16:0] mul;
  logic [EXP_VAL_W-1:0] val_q;

  assign zero = |arg_i[EXP_ARG_W-1:20];
  assign prod = PosW'(arg_i[19:0]) * PosW'(EXP_TABLE_DEPTH);
  assign pos  = prod[PosW-1:4];
  assign idx  = pos[16 +: EXP_IDX_W];
  assign a    = EXP_ROM[EXP_ROM_W'(idx)];
  assign b    = EXP_ROM[EXP_ROM_W'(idx) + EXP_ROM_W'(1)];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q    <= a;
      diff_q <= a - b;
      frac_q <= pos[15:0];
      zero_q <= zero;
    end
  end

  assign mul = (EXP_VAL_W+17)'(diff_q) * (EXP_VAL_W+17)'(frac_q) + (EXP_VAL_W+17)'(32768);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      val_q <= zero_q ? '0 : a_q - mul[EXP_VAL_W+15:16];
    end
  end

  assign val_o = val_q;

endmodule

// ===== src/csls_hg_lobe.sv =====
// One Henyey-Greenstein phase lobe: pipelined square root and divider.
// Depends on csls_pkg for widths and step counts.
`timescale 1ns / 1ps
module csls_hg_lobe import csls_pkg::*; (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic signed [14:0]  g_i,
  input  logic signed [15:0]  c_i,
  output logic [LOBE_W-1:0]   phase_o
);

  logic signed [14:0] gcl;
  logic signed [14:0] gcl_q;
  logic signed [29:0] gsq;
  logic [27:0]        g2_q;
  logic [28:0]        num;
  logic signed [30:0] gc_q;
  logic signed [32:0] den_s;

  logic [57:0] sv_q [SQRT_STEPS+1];
  logic [58:0] sr_q [SQRT_STEPS+1];
  logic [29:0] sd_q [SQRT_STEPS+1];
  logic [58:0] sbit   [SQRT_STEPS];
  logic [58:0] strial [SQRT_STEPS];
  logic        stake  [SQRT_STEPS];

  logic [58:0] mprod_q;
  logic [59:0] d15_sum;
  logic [30:0] d15;
  logic [44:0] dividend;

  logic [31:0] drem_q [DIV_STEPS+1];
  logic [29:0] dsh_q  [DIV_STEPS+1];
  logic [30:0] ddiv_q [DIV_STEPS+1];
  logic [31:0] dtrial [DIV_STEPS];
  logic        dtake  [DIV_STEPS];

  logic [58:0] qprod_q;
  logic [59:0] qround;
  logic [LOBE_W-1:0] phase_q;

  always_comb begin
    if (g_i > G_LIMIT) begin
      gcl = G_LIMIT;
    end else if (g_i < -G_LIMIT) begin
      gcl = -G_LIMIT;
    end else begin
      gcl = g_i;
    end
  end

  // Lobe shape follows the registers; the user, not the block, holds them still while samples flow.
  assign gsq = 30'(gcl_q) * 30'(gcl_q);
  always_ff @(posedge clk_i) begin
    gcl_q <= gcl;
    g2_q  <= gsq[27:0];
  end
  assign num = 29'h1000_0000 - {1'b0, g2_q};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      gc_q <= 31'(gcl_q) * 31'(c_i);
    end
  end

  assign den_s = 33'sd268435456 + 33'(signed'({1'b0, g2_q})) - 33'(gc_q) * 33'sd2;

  always_comb begin
    for (int k = 0; k < SQRT_STEPS; k++) begin
      sbit[k]   = 59'(1) << (2 * (SQRT_STEPS - 1 - k));
      strial[k] = sr_q[k] + sbit[k];
      stake[k]  = {1'b0, sv_q[k]} >= strial[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sv_q[0] <= {den_s[29:0], 28'b0};
      sr_q[0] <= '0;
      sd_q[0] <= den_s[29:0];
      for (int k = 0; k < SQRT_STEPS; k++) begin
        sv_q[k+1] <= stake[k] ? sv_q[k] - strial[k][57:0] : sv_q[k];
        sr_q[k+1] <= stake[k] ? (sr_q[k] >> 1) + sbit[k] : sr_q[k] >> 1;
        sd_q[k+1] <= sd_q[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mprod_q <= 59'(sd_q[SQRT_STEPS]) * 59'(sr_q[SQRT_STEPS][28:0]);
    end
  end

  assign d15_sum  = 60'(mprod_q) + 60'(28'h800_0000);
  assign d15      = d15_sum[58:28];
  assign dividend = {num, 16'b0} + 45'(d15[30:1]);

  always_comb begin
    for (int k = 0; k < DIV_STEPS; k++) begin
      dtrial[k] = {drem_q[k][30:0], dsh_q[k][29]};
      dtake[k]  = dtrial[k] >= {1'b0, ddiv_q[k]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      drem_q[0] <= 32'(dividend[44:30]);
      dsh_q[0]  <= dividend[29:0];
      ddiv_q[0] <= d15;
      for (int k = 0; k < DIV_STEPS; k++) begin
        drem_q[k+1] <= dtake[k] ? dtrial[k] - {1'b0, ddiv_q[k]} : dtrial[k];
        dsh_q[k+1]  <= {dsh_q[k][28:0], dtake[k]};
        ddiv_q[k+1] <= ddiv_q[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      qprod_q <= 59'(dsh_q[DIV_STEPS]) * 59'(INV_FOUR_PI);
    end
  end

  assign qround = 60'(qprod_q) + 60'(32'h8000_0000);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      phase_q <= qround[32 +: LOBE_W];
    end
  end

  assign phase_o = phase_q;

endmodule

// ===== src/cloud_sample_light_shade.sv =====
// Top level of the cloud sample shading block: registers, pipeline, outputs.
// Depends on csls_pkg, csls_stream_if, csls_exp_neg and csls_hg_lobe.
`timescale 1ns / 1ps
// The block takes one sample word per clock while it is not held, and returns
// one shade word per sample, in order. The depth of the pipeline comes mostly
// from the phase lobes, each of which runs a 29-stage square root and a
// 30-stage divider. The whole pipeline holds while a finished word is not
// taken, so ready follows the output side; samples carry no state between them.
module cloud_sample_light_shade import csls_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  csls_sample_if.sink           sample_i,
  csls_shade_if.source          shade_o
);

  typedef struct packed {
    logic [2:0][21:0] b;
    logic [2:0][16:0] amb;
    logic [15:0]      dens;
  } side_t;

  logic [23:0]        sun_rgb_q;
  logic [15:0]        sun_strength_q;
  logic [23:0]        sky_top_q;
  logic [23:0]        sky_bottom_q;
  logic signed [14:0] lobe_fwd_g_q;
  logic signed [14:0] lobe_back_g_q;
  logic [15:0]        lobe_back_w_q;
  logic [31:0]        atten_q;

  logic               en;
  logic [STG_LAST:1]  vld_q;

  logic signed [31:0] prx_q, pry_q, prz_q;
  logic [31:0]        mabs_q, mpow_q;
  logic [15:0]        dens1_q, dens2_q, dens3_q, dens4_q;
  logic [16:0]        h1_q;
  logic [16:0]        h_clamp;

  logic signed [33:0] dot, cr;
  logic signed [15:0] c_d, c_q;
  logic [EXP_ARG_W-1:0] xt, xp, xa;
  logic [32:0]        xt_sum, xp_sum;
  logic [EXP_VAL_W-1:0] trans, pexp, ambt;

  logic [16:0]        amb2_q [3];
  logic [16:0]        amb3_q [3];
  logic [16:0]        ambt4_q [3];
  logic [16:0]        energy_q;
  logic [23:0]        a_q [3];

  logic [25:0]        mix [3];
  logic [33:0]        emul;
  logic [33:0]        amul [3];
  logic [40:0]        bmul [3];

  side_t              side_d;
  side_t              side_q [SIDE_LEN];

  logic [LOBE_W-1:0]  pf, pb, pf_q;
  logic [38:0]        wprod_q;
  logic [39:0]        wround;
  logic [PHASE_W-1:0] phase_q;

  logic [47:0]        dprod_q [3];
  logic [16:0]        amb70_q [3];
  logic [15:0]        dens70_q, dens71_q;
  logic [48:0]        dround [3];
  logic [33:0]        sum_q [3];
  logic [49:0]        rprod_q [3];
  logic [50:0]        rround [3];
  logic [15:0]        chan [3];
  shade_t             out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sun_rgb_q      <= 24'h7A7D80;
      sun_strength_q <= 16'd4096;
      sky_top_q      <= 24'h735A4D;
      sky_bottom_q   <= 24'h26201A;
      lobe_fwd_g_q   <= 15'sd9830;
      lobe_back_g_q  <= -15'sd3277;
      lobe_back_w_q  <= 16'd8192;
      atten_q        <= 32'h1000_0800;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_SUN_COLOR:    sun_rgb_q      <= cfg_data_i[23:0];
        CFG_SUN_STRENGTH: sun_strength_q <= cfg_data_i[15:0];
        CFG_SKY_TOP:      sky_top_q      <= cfg_data_i[23:0];
        CFG_SKY_BOTTOM:   sky_bottom_q   <= cfg_data_i[23:0];
        CFG_LOBE_FWD_G:   lobe_fwd_g_q   <= cfg_data_i[14:0];
        CFG_LOBE_BACK_G:  lobe_back_g_q  <= cfg_data_i[14:0];
        CFG_LOBE_BACK_W:  lobe_back_w_q  <= cfg_data_i[15:0];
        CFG_ATTEN:        atten_q        <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  assign en = !vld_q[STG_LAST] || shade_o.ready;
  assign sample_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[STG_LAST-1:1], sample_i.valid};
    end
  end

  assign h_clamp = (sample_i.payload.height_frac > 17'h10000) ? 17'h10000 :
                   sample_i.payload.height_frac;

  always_ff @(posedge clk_i) begin
    if (en) begin
      prx_q   <= 32'(sample_i.payload.view_x) * 32'(sample_i.payload.light_x);
      pry_q   <= 32'(sample_i.payload.view_y) * 32'(sample_i.payload.light_y);
      prz_q   <= 32'(sample_i.payload.view_z) * 32'(sample_i.payload.light_z);
      mabs_q  <= 32'(sample_i.payload.depth_to_sun) * 32'(atten_q[15:0]);
      mpow_q  <= 32'(sample_i.payload.depth_to_sun) * 32'(atten_q[31:16]);
      dens1_q <= sample_i.payload.sample_density;
      h1_q    <= h_clamp;
    end
  end

  assign dot = 34'(prx_q) + 34'(pry_q) + 34'(prz_q);
  assign cr  = (dot + 34'sd8192) >>> 14;

  always_comb begin
    if (cr > 34'sd16384) begin
      c_d = 16'sd16384;
    end else if (cr < -34'sd16384) begin
      c_d = -16'sd16384;
    end else begin
      c_d = cr[15:0];
    end
  end

  assign xt_sum = 33'(mabs_q) + 33'd8;
  assign xp_sum = 33'(mpow_q) + 33'd4;
  assign xt = EXP_ARG_W'(xt_sum >> 4);
  assign xp = EXP_ARG_W'(xp_sum >> 3);
  assign xa = EXP_ARG_W'({dens1_q, 7'b0});

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      mix[ch] = 26'(sky_bottom_q[ch*8 +: 8]) * 26'(17'h10000 - h1_q)
              + 26'(sky_top_q[ch*8 +: 8]) * 26'(h1_q) + 26'd64;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c_q     <= c_d;
      dens2_q <= dens1_q;
      dens3_q <= dens2_q;
      dens4_q <= dens3_q;
      for (int ch = 0; ch < 3; ch++) begin
        amb2_q[ch] <= mix[ch][23:7];
        amb3_q[ch] <= amb2_q[ch];
      end
    end
  end

  csls_exp_neg u_exp_trans (.clk_i(clk_i), .en_i(en), .arg_i(xt), .val_o(trans));
  csls_exp_neg u_exp_powder (.clk_i(clk_i), .en_i(en), .arg_i(xp), .val_o(pexp));
  csls_exp_neg u_exp_ambient (.clk_i(clk_i), .en_i(en), .arg_i(xa), .val_o(ambt));

  assign emul = 34'(trans) * 34'(17'h10000 - pexp) + 34'd32768;

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      amul[ch] = 34'(amb3_q[ch]) * 34'(ambt) + 34'd32768;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      energy_q <= emul[32:16];
      for (int ch = 0; ch < 3; ch++) begin
        ambt4_q[ch] <= amul[ch][32:16];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int ch = 0; ch < 3; ch++) begin
      a_q[ch] <= 24'(sun_rgb_q[ch*8 +: 8]) * 24'(sun_strength_q);
    end
  end

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      bmul[ch] = 41'(a_q[ch]) * 41'(energy_q) + 41'(20'h40000);
      side_d.b[ch]   = bmul[ch][40:19];
      side_d.amb[ch] = ambt4_q[ch];
    end
    side_d.dens = dens4_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= side_d;
      for (int k = 1; k < SIDE_LEN; k++) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  csls_hg_lobe u_lobe_fwd (
    .clk_i(clk_i), .en_i(en), .g_i(lobe_fwd_g_q), .c_i(c_q), .phase_o(pf)
  );
  csls_hg_lobe u_lobe_back (
    .clk_i(clk_i), .en_i(en), .g_i(lobe_back_g_q), .c_i(c_q), .phase_o(pb)
  );

  assign wround = 40'(wprod_q) + 40'd8192;

  always_ff @(posedge clk_i) begin
    if (en) begin
      wprod_q <= 39'(pb) * 39'(lobe_back_w_q);
      pf_q    <= pf;
      phase_q <= PHASE_W'(pf_q) + PHASE_W'(wround >> 14);
    end
  end

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      dround[ch] = 49'(dprod_q[ch]) + 49'd32768;
      rround[ch] = 51'(rprod_q[ch]) + 51'd32768;
      chan[ch]   = (|rround[ch][50:32]) ? 16'hFFFF : rround[ch][31:16];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dens70_q <= side_q[SIDE_LEN-1].dens;
      dens71_q <= dens70_q;
      for (int ch = 0; ch < 3; ch++) begin
        dprod_q[ch] <= 48'(side_q[SIDE_LEN-1].b[ch]) * 48'(phase_q);
        amb70_q[ch] <= side_q[SIDE_LEN-1].amb[ch];
        sum_q[ch]   <= 34'(dround[ch] >> 16) + 34'(amb70_q[ch]);
        rprod_q[ch] <= 50'(sum_q[ch]) * 50'(dens71_q);
      end
      out_q.red_out   <= chan[0];
      out_q.green_out <= chan[1];
      out_q.blue_out  <= chan[2];
    end
  end

  assign shade_o.valid   = vld_q[STG_LAST];
  assign shade_o.payload = out_q;

endmodule
